FILE: rtl/div128_pkg.sv
// Shared types and constants for the 128-bit pipelined divider.
// Used by every module of the divider; depends on nothing.
package div128_pkg;

    localparam int unsigned WordW  = 128;
    localparam int unsigned HalfW  = 64;
    localparam int unsigned NSteps = WordW;

    // One item in flight through the divide pipeline
    typedef struct packed {
        logic             vld;
        logic             neg_q;
        logic             neg_r;
        logic             dz;
        logic [WordW-1:0] num;
        logic [WordW-1:0] rem;
        logic [WordW-1:0] den;
    } t_stage;

    // Two's complement negation of a full word
    function automatic logic [WordW-1:0] neg128(input logic [WordW-1:0] v);
        return (~v) + {{(WordW-1){1'b0}}, 1'b1};
    endfunction

endpackage

FILE: rtl/div128_pre.sv
// Input stage: takes operand magnitudes and records signs and zero divisor.
// Depends on div128_pkg.
module div128_pre (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_vld,
    input  logic                          i_signed,
    input  logic [div128_pkg::WordW-1:0]  i_num,
    input  logic [div128_pkg::WordW-1:0]  i_den,
    output div128_pkg::t_stage            o_stage
);

    div128_pkg::t_stage r_stage;
    div128_pkg::t_stage n_stage;
    logic               num_neg;
    logic               den_neg;

    // Work out signs and magnitudes
    always_comb begin
        num_neg         = i_signed & i_num[div128_pkg::WordW-1];
        den_neg         = i_signed & i_den[div128_pkg::WordW-1];
        n_stage.vld     = i_vld;
        n_stage.neg_q   = num_neg ^ den_neg;
        n_stage.neg_r   = num_neg;
        n_stage.dz      = (i_den == '0);
        n_stage.num     = num_neg ? div128_pkg::neg128(i_num) : i_num;
        n_stage.den     = den_neg ? div128_pkg::neg128(i_den) : i_den;
        n_stage.rem     = '0;
    end

    // Hold valid under reset, payload on enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage.vld <= n_stage.vld;
        end
        if (i_en) begin
            r_stage.neg_q <= n_stage.neg_q;
            r_stage.neg_r <= n_stage.neg_r;
            r_stage.dz    <= n_stage.dz;
            r_stage.num   <= n_stage.num;
            r_stage.rem   <= n_stage.rem;
            r_stage.den   <= n_stage.den;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/div128_step.sv
// One restoring shift-and-subtract step of the divide, registered.
// Depends on div128_pkg.
module div128_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  div128_pkg::t_stage  i_stage,
    output div128_pkg::t_stage  o_stage
);

    div128_pkg::t_stage               r_stage;
    div128_pkg::t_stage               n_stage;
    logic [div128_pkg::WordW:0]       rem_sh;
    logic [div128_pkg::WordW+1:0]     diff;
    logic                             ge;

    // Shift in the next dividend bit, try the subtract, keep quotient bit
    always_comb begin
        rem_sh  = {i_stage.rem, i_stage.num[div128_pkg::WordW-1]};
        diff    = {1'b0, rem_sh} - {2'b00, i_stage.den};
        ge      = ~diff[div128_pkg::WordW+1];
        n_stage = i_stage;
        n_stage.rem = ge ? diff[div128_pkg::WordW-1:0] : rem_sh[div128_pkg::WordW-1:0];
        n_stage.num = {i_stage.num[div128_pkg::WordW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.vld <= 1'b0;
        end else if (i_en) begin
            r_stage.vld <= n_stage.vld;
        end
        if (i_en) begin
            r_stage.neg_q <= n_stage.neg_q;
            r_stage.neg_r <= n_stage.neg_r;
            r_stage.dz    <= n_stage.dz;
            r_stage.num   <= n_stage.num;
            r_stage.rem   <= n_stage.rem;
            r_stage.den   <= n_stage.den;
        end
    end

    assign o_stage = r_stage;

endmodule

FILE: rtl/div128_post.sv
// Output stage: applies result signs and the zero-divisor remainder.
// Depends on div128_pkg; its register is the block's output register.
module div128_post (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  div128_pkg::t_stage            i_stage,
    output logic                          o_vld,
    output logic [div128_pkg::WordW-1:0]  o_quo,
    output logic [div128_pkg::WordW-1:0]  o_rem,
    output logic                          o_dz
);

    logic                         r_vld;
    logic [div128_pkg::WordW-1:0] r_quo;
    logic [div128_pkg::WordW-1:0] r_rem;
    logic                         r_dz;
    logic [div128_pkg::WordW-1:0] n_quo;
    logic [div128_pkg::WordW-1:0] n_rem;
    logic [div128_pkg::WordW-1:0] rem_raw;

    // Drop the remainder on a zero divisor, then fix signs
    always_comb begin
        rem_raw = i_stage.dz ? '0 : i_stage.rem;
        n_quo   = i_stage.neg_q ? div128_pkg::neg128(i_stage.num) : i_stage.num;
        n_rem   = i_stage.neg_r ? div128_pkg::neg128(rem_raw) : rem_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_stage.vld;
        end
        if (i_en) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
            r_dz  <= i_stage.dz;
        end
    end

    assign o_vld = r_vld;
    assign o_quo = r_quo;
    assign o_rem = r_rem;
    assign o_dz  = r_dz;

endmodule

FILE: rtl/divider_128bit_signed_unsigned_unit.sv
// Top level of the 128-bit signed/unsigned pipelined divider.
// Depends on div128_pkg, div128_pre, div128_step and div128_post.
//
// Usage:
//   Input stream (s_axis): tuser = action (0 unsigned, 1 signed), tdata
//   carries dividend and divisor as 64-bit halves. Output stream (m_axis):
//   tdata carries quotient and remainder halves, tuser the divide-by-zero
//   flag. Signed mode truncates toward zero; the remainder takes the sign
//   of the dividend. A zero divisor gives an all-ones quotient (negated by
//   the dividend sign in signed mode), a zero remainder and the flag.
//   One operand stage, 128 restoring subtract stages (one quotient bit
//   each, one 129-bit subtract per stage) and one output stage. Throughput
//   is one item per cycle while the receiver does not stall.
//   The whole pipeline advances together whenever the output register is
//   empty or being taken; while the receiver stalls with a result waiting,
//   the pipeline and s_axis_tready hold and no item is lost or repeated.
//   Reset clears all valid bits; the pipeline is empty afterwards.
module divider_128bit_signed_unsigned_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [63:0] dividend_hi, [127:64] dividend_lo, [191:128] divisor_hi,
    // [255:192] divisor_lo
    input  logic [255:0] s_axis_tdata,
    // [0] action
    input  logic [0:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] quotient_hi, [127:64] quotient_lo, [191:128] remainder_hi,
    // [255:192] remainder_lo
    output logic [255:0] m_axis_tdata,
    // [0] divide_by_zero
    output logic [0:0]   m_axis_tuser
);

    div128_pkg::t_stage               stg [div128_pkg::NSteps+1];
    logic                             en;
    logic [div128_pkg::WordW-1:0]     num_in;
    logic [div128_pkg::WordW-1:0]     den_in;
    logic [div128_pkg::WordW-1:0]     quo;
    logic [div128_pkg::WordW-1:0]     rem;
    logic                             dz;

    // Advance every stage when the output slot is empty or being taken
    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    assign num_in = {s_axis_tdata[div128_pkg::HalfW-1:0],
                     s_axis_tdata[2*div128_pkg::HalfW-1:div128_pkg::HalfW]};
    assign den_in = {s_axis_tdata[3*div128_pkg::HalfW-1:2*div128_pkg::HalfW],
                     s_axis_tdata[4*div128_pkg::HalfW-1:3*div128_pkg::HalfW]};

    div128_pre u_pre (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_vld    (s_axis_tvalid),
        .i_signed (s_axis_tuser[0]),
        .i_num    (num_in),
        .i_den    (den_in),
        .o_stage  (stg[0])
    );

    // Chain of restoring steps, most significant quotient bit first
    for (genvar k = 0; k < div128_pkg::NSteps; k++) begin : g_step
        div128_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_stage (stg[k]),
            .o_stage (stg[k+1])
        );
    end

    div128_post u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_stage (stg[div128_pkg::NSteps]),
        .o_vld   (m_axis_tvalid),
        .o_quo   (quo),
        .o_rem   (rem),
        .o_dz    (dz)
    );

    assign m_axis_tdata = {rem[div128_pkg::HalfW-1:0],
                           rem[2*div128_pkg::HalfW-1:div128_pkg::HalfW],
                           quo[div128_pkg::HalfW-1:0],
                           quo[2*div128_pkg::HalfW-1:div128_pkg::HalfW]};
    assign m_axis_tuser = dz;

endmodule

FILE: tb/sv/divider_128bit_signed_unsigned_unit_tb.sv
// Self-checking bench for the 128-bit signed/unsigned pipelined divider.
// Drives operand items with random gaps and stalls, predicts each quotient
// and remainder with a bit-serial restoring divide, and checks in order.
module divider_128bit_signed_unsigned_unit_tb;

    localparam int unsigned PipeLatency = 130;
    localparam int unsigned CycleLimit  = 400000;
    localparam logic        ModeSigned   = 1'b1;

    typedef struct packed {
        logic         dz;
        logic [127:0] rem;
        logic [127:0] quo;
    } t_div_result;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // [63:0] dividend_hi, [127:64] dividend_lo, [191:128] divisor_hi,
    // [255:192] divisor_lo
    logic [255:0] s_axis_tdata;
    // [0] action
    logic [0:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // [63:0] quotient_hi, [127:64] quotient_lo, [191:128] remainder_hi,
    // [255:192] remainder_lo
    logic [255:0] m_axis_tdata;
    // [0] divide_by_zero
    logic [0:0]   m_axis_tuser;

    t_div_result  pending_quotients[$];
    int unsigned  fail_count;
    int unsigned  result_count;
    int unsigned  cycle_count;
    int unsigned  sender_idle_pct;
    int unsigned  receiver_stall_pct;
    int unsigned  signed_count;
    int unsigned  zero_div_count;

    divider_128bit_signed_unsigned_unit dut (.*);

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Restoring divide of the magnitudes, then fix up the signs
    function automatic t_div_result predict_divide(input logic mode,
            input logic [127:0] num, input logic [127:0] den);
        t_div_result res;
        logic [128:0] part;
        logic         n_neg;
        logic         d_neg;
        n_neg = (mode == ModeSigned) && num[127];
        d_neg = (mode == ModeSigned) && den[127];
        if (n_neg) num = -num;
        if (d_neg) den = -den;
        res = '0;
        if (den == '0) begin
            res.quo = '1;
            res.dz  = 1'b1;
        end else begin
            part = '0;
            for (int i = 127; i >= 0; i--) begin
                part = {part[127:0], num[i]};
                if (part >= {1'b0, den}) begin
                    part = part - {1'b0, den};
                    res.quo[i] = 1'b1;
                end
            end
            res.rem = part[127:0];
        end
        if (n_neg != d_neg) res.quo = -res.quo;
        if (n_neg) res.rem = -res.rem;
        return res;
    endfunction

    // Send one item, recording its expected result when it is taken
    task automatic send_divide(input logic mode, input logic [127:0] num,
            input logic [127:0] den);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {den[63:0], den[127:64], num[63:0], num[127:64]};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_quotients.push_back(predict_divide(mode, num, den));
        if (mode == ModeSigned) signed_count++;
        if (den == '0) zero_div_count++;
    endtask

    // Random operand with varied magnitude so quotients span all sizes
    function automatic logic [127:0] rand_operand();
        logic [127:0] v;
        int unsigned  sh;
        v  = {$urandom, $urandom, $urandom, $urandom};
        sh = $urandom_range(127);
        case ($urandom_range(5))
            0: v = v >> sh;
            1: v = -(v >> sh);
            2: v = 128'($urandom_range(3));
            3: v = {1'b1, 127'b0} ^ 128'($urandom_range(1));
            default: ;
        endcase
        return v;
    endfunction

    // Drive receiver back-pressure
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_div_result want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            result_count <= result_count + 1;
            if (pending_quotients.size() == 0) begin
                $display("%0t: unexpected result q=%h r=%h dz=%b", $time,
                    {m_axis_tdata[63:0], m_axis_tdata[127:64]},
                    {m_axis_tdata[191:128], m_axis_tdata[255:192]}, m_axis_tuser);
                fail_count++;
            end else begin
                want = pending_quotients.pop_front();
                if ({m_axis_tdata[63:0], m_axis_tdata[127:64]} != want.quo) begin
                    $display("%0t: quotient expected %h actual %h", $time, want.quo,
                        {m_axis_tdata[63:0], m_axis_tdata[127:64]});
                    fail_count++;
                end
                if ({m_axis_tdata[191:128], m_axis_tdata[255:192]} != want.rem) begin
                    $display("%0t: remainder expected %h actual %h", $time, want.rem,
                        {m_axis_tdata[191:128], m_axis_tdata[255:192]});
                    fail_count++;
                end
                if (m_axis_tuser[0] != want.dz) begin
                    $display("%0t: divide_by_zero expected %b actual %b", $time,
                        want.dz, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        if (cycle_count > CycleLimit) begin
            $display("** divider_128bit_signed_unsigned_unit: FAILED **");
            $finish;
        end
    end

    // Extremes, zero divisors and most-negative cases in both modes
    task automatic test_directed();
        logic [127:0] min_neg;
        min_neg = {1'b1, 127'b0};
        for (int m = 0; m < 2; m++) begin
            send_divide(m[0], 128'd100, 128'd7);
            send_divide(m[0], -128'sd100, 128'd7);
            send_divide(m[0], 128'd100, -128'sd7);
            send_divide(m[0], -128'sd100, -128'sd7);
            send_divide(m[0], 128'd55, '0);
            send_divide(m[0], -128'sd55, '0);
            send_divide(m[0], '0, '0);
            send_divide(m[0], '1, '1);
            send_divide(m[0], '1, 128'd1);
            send_divide(m[0], min_neg, '1);
            send_divide(m[0], min_neg, min_neg);
            send_divide(m[0], min_neg - 128'd1, min_neg);
        end
    endtask

    // Random divides under one idling pattern
    task automatic test_random(input int unsigned count, input int unsigned idle,
            input int unsigned stall);
        sender_idle_pct    = idle;
        receiver_stall_pct = stall;
        for (int unsigned k = 0; k < count; k++) begin
            send_divide(1'($urandom_range(1)), rand_operand(), rand_operand());
        end
    endtask

    // Wait for the pipeline to drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_quotients.size() != 0) @(posedge i_clk);
        repeat (PipeLatency + 10) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n         = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        m_axis_tready   = 1'b0;
        fail_count      = 0;
        result_count    = 0;
        cycle_count     = 0;
        signed_count    = 0;
        zero_div_count  = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(200, 0, 0);
        test_random(150, 79, 0);
        test_random(150, 0, 79);
        test_random(100, 6, 6);
        receiver_stall_pct = 0;
        drain();
        $display("Checked %0d divides (%0d signed, %0d by zero) under four idling patterns.",
            result_count, signed_count, zero_div_count);
        if (fail_count == 0) begin
            $display("** divider_128bit_signed_unsigned_unit: PASSED **");
        end else begin
            $display("** divider_128bit_signed_unsigned_unit: FAILED **");
        end
        $finish;
    end

endmodule
